[design/keyword_token_lexer_assert.svh]
// assertion macros for the keyword token lexer
// expects aclk and aresetn in the scope where they are used
`ifndef KEYWORD_TOKEN_LEXER_ASSERT_SVH
`define KEYWORD_TOKEN_LEXER_ASSERT_SVH

// same-cycle implication, off while in reset
`define KLEX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lexer check failed");

// next-cycle implication, off while in reset
`define KLEX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lexer check failed");

// condition that must hold in the cycle after reset is applied
`define KLEX_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error("lexer reset check failed");

`endif

[design/klex_pkg.sv]
// shared types, token kind codes and keyword tables for the keyword token lexer
// no dependencies
`timescale 1ns / 1ps

package klex_pkg;

    localparam logic [4:0] KIND_VAR       = 5'd0;
    localparam logic [4:0] KIND_IDENT     = 5'd1;
    localparam logic [4:0] KIND_SEMI      = 5'd2;
    localparam logic [4:0] KIND_START     = 5'd3;
    localparam logic [4:0] KIND_END       = 5'd4;
    localparam logic [4:0] KIND_PRINT     = 5'd5;
    localparam logic [4:0] KIND_LPAREN    = 5'd6;
    localparam logic [4:0] KIND_RPAREN    = 5'd7;
    localparam logic [4:0] KIND_READ      = 5'd8;
    localparam logic [4:0] KIND_IF        = 5'd9;
    localparam logic [4:0] KIND_LBRACE    = 5'd10;
    localparam logic [4:0] KIND_RBRACE    = 5'd11;
    localparam logic [4:0] KIND_ITERATION = 5'd12;
    localparam logic [4:0] KIND_PUT       = 5'd13;
    localparam logic [4:0] KIND_EQ        = 5'd14;
    localparam logic [4:0] KIND_LT        = 5'd15;
    localparam logic [4:0] KIND_GT        = 5'd16;
    localparam logic [4:0] KIND_EQEQ      = 5'd17;
    localparam logic [4:0] KIND_PLUS      = 5'd18;
    localparam logic [4:0] KIND_MINUS     = 5'd19;
    localparam logic [4:0] KIND_TIMES     = 5'd20;
    localparam logic [4:0] KIND_INT       = 5'd21;
    localparam logic [4:0] KIND_EOF       = 5'd22;
    localparam logic [4:0] KIND_ERR       = 5'd23;

    localparam int NUM_KW     = 8;
    localparam int KW_MAXLEN  = 9;
    localparam int QDEPTH     = 3;

    typedef struct packed {
        logic       last;
        logic [7:0] length;
        logic [15:0] start;
        logic [4:0] kind;
    } token_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    // keyword text, left justified in nine bytes
    function automatic logic [8*KW_MAXLEN-1:0] kw_str(input logic [2:0] k);
        logic [8*KW_MAXLEN-1:0] s;
        unique case (k)
            3'd0: s = {"Var", 48'h0};
            3'd1: s = {"Start", 32'h0};
            3'd2: s = {"End", 48'h0};
            3'd3: s = {"Print", 32'h0};
            3'd4: s = {"Read", 40'h0};
            3'd5: s = {"If", 56'h0};
            3'd6: s = "Iteration";
            3'd7: s = {"Put", 48'h0};
        endcase
        return s;
    endfunction

    function automatic logic [7:0] kw_len(input logic [2:0] k);
        logic [7:0] n;
        unique case (k)
            3'd0: n = 8'd3;
            3'd1: n = 8'd5;
            3'd2: n = 8'd3;
            3'd3: n = 8'd5;
            3'd4: n = 8'd4;
            3'd5: n = 8'd2;
            3'd6: n = 8'd9;
            3'd7: n = 8'd3;
        endcase
        return n;
    endfunction

    function automatic logic [4:0] kw_kind(input logic [2:0] k);
        logic [4:0] n;
        unique case (k)
            3'd0: n = KIND_VAR;
            3'd1: n = KIND_START;
            3'd2: n = KIND_END;
            3'd3: n = KIND_PRINT;
            3'd4: n = KIND_READ;
            3'd5: n = KIND_IF;
            3'd6: n = KIND_ITERATION;
            3'd7: n = KIND_PUT;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [7:0] idx);
        logic [8*KW_MAXLEN-1:0] s;
        logic [7:0] ch;
        s  = kw_str(k);
        ch = 8'h00;
        for (int i = 0; i < KW_MAXLEN; i++) begin
            if (idx == 8'(i)) begin
                ch = s[8*(KW_MAXLEN-i)-1 -: 8];
            end
        end
        return ch;
    endfunction

    // keep the candidates whose character at offset idx is c
    function automatic logic [NUM_KW-1:0] narrow(input logic [NUM_KW-1:0] cand,
                                                 input logic [7:0] idx,
                                                 input logic [7:0] c);
        logic [NUM_KW-1:0] m;
        for (int k = 0; k < NUM_KW; k++) begin
            m[k] = cand[k] && (idx < kw_len(3'(k))) && (kw_char(3'(k), idx) == c);
        end
        return m;
    endfunction

    // lowest candidate whose length matches, else identifier
    function automatic logic [4:0] ident_kind(input logic [NUM_KW-1:0] cand,
                                              input logic [7:0] len);
        logic [4:0] kind;
        kind = KIND_IDENT;
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (cand[k] && (kw_len(3'(k)) == len)) begin
                kind = kw_kind(3'(k));
            end
        end
        return kind;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] kind;
        unique case (c)
            ";":     kind = KIND_SEMI;
            "(":     kind = KIND_LPAREN;
            ")":     kind = KIND_RPAREN;
            "{":     kind = KIND_LBRACE;
            "}":     kind = KIND_RBRACE;
            "<":     kind = KIND_LT;
            ">":     kind = KIND_GT;
            "+":     kind = KIND_PLUS;
            "-":     kind = KIND_MINUS;
            "*":     kind = KIND_TIMES;
            default: kind = KIND_ERR;
        endcase
        return kind;
    endfunction

endpackage

[design/klex_scan.sv]
// scanner state and per-byte token decode, up to two tokens per byte
// depends on klex_pkg
`timescale 1ns / 1ps

module klex_scan
    import klex_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int INPUT_SPAN    = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        proc,
    input  logic [7:0]  char_code,
    output token_t      tok0,
    output token_t      tok1,
    output logic [1:0]  push_n
);

    localparam int PW = $clog2(INPUT_SPAN);
    localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN);
    localparam logic [PW-1:0] POS_LAST = PW'(INPUT_SPAN - 1);

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_IDENT = 2'd1;
    localparam logic [1:0] MODE_INT   = 2'd2;
    localparam logic [1:0] MODE_EQ    = 2'd3;

    logic [1:0]        mode_reg, mode_next;
    logic [NUM_KW-1:0] cand_reg, cand_next;
    logic [7:0]        len_reg, len_next;
    logic [PW-1:0]     start_reg, start_next;
    logic [PW-1:0]     pos_reg, pos_next;

    token_t run_tok, byte_tok;
    logic   run_v, byte_v, pass;

    always_comb begin
        mode_next  = mode_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        start_next = start_reg;
        pos_next   = pos_reg;
        run_tok    = '0;
        byte_tok   = '0;
        run_v      = 1'b0;
        byte_v     = 1'b0;
        pass       = 1'b1;
        if (proc) begin
            run_tok.start = 16'(start_reg);
            run_tok.length = len_reg;
            unique case (mode_reg)
                MODE_IDLE: begin
                end
                MODE_IDENT: begin
                    if (is_letter(char_code) || is_digit(char_code)) begin
                        if (len_reg < LEN_CAP) begin
                            cand_next = narrow(cand_reg, len_reg, char_code);
                            len_next  = len_reg + 8'd1;
                        end else begin
                            cand_next = '0;
                        end
                        pass = 1'b0;
                    end else begin
                        run_v = 1'b1;
                        run_tok.kind = (len_reg >= LEN_CAP) ? KIND_IDENT
                                                           : ident_kind(cand_reg, len_reg);
                    end
                end
                MODE_INT: begin
                    if (is_digit(char_code)) begin
                        if (len_reg < LEN_CAP) begin
                            len_next = len_reg + 8'd1;
                        end
                        pass = 1'b0;
                    end else begin
                        run_v = 1'b1;
                        run_tok.kind = KIND_INT;
                    end
                end
                MODE_EQ: begin
                    run_v = 1'b1;
                    if (char_code == "=") begin
                        run_tok.kind   = KIND_EQEQ;
                        run_tok.length = 8'd2;
                        pass = 1'b0;
                    end else begin
                        run_tok.kind   = KIND_EQ;
                        run_tok.length = 8'd1;
                    end
                end
            endcase

            // end of run or pending equals: back to idle
            if (run_v) begin
                mode_next  = MODE_IDLE;
                cand_next  = '0;
                len_next   = 8'd0;
                start_next = '0;
            end

            if (pass) begin
                byte_tok.start  = 16'(pos_reg);
                byte_tok.length = 8'd1;
                priority if (is_space(char_code)) begin
                end else if (is_letter(char_code)) begin
                    mode_next  = MODE_IDENT;
                    start_next = pos_reg;
                    cand_next  = narrow('1, 8'd0, char_code);
                    len_next   = 8'd1;
                end else if (is_digit(char_code)) begin
                    mode_next  = MODE_INT;
                    start_next = pos_reg;
                    cand_next  = '0;
                    len_next   = 8'd1;
                end else if (char_code == "=") begin
                    mode_next  = MODE_EQ;
                    start_next = pos_reg;
                    cand_next  = '0;
                    len_next   = 8'd1;
                end else if (char_code == 8'h00) begin
                    byte_v          = 1'b1;
                    byte_tok.kind   = KIND_EOF;
                    byte_tok.length = 8'd0;
                end else begin
                    byte_v        = 1'b1;
                    byte_tok.kind = punct_kind(char_code);
                end
            end

            if ((char_code == 8'h00) || (pos_reg == POS_LAST)) begin
                pos_next = '0;
            end else begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_comb begin
        push_n = 2'(run_v) + 2'(byte_v);
        tok0 = run_v ? run_tok : byte_tok;
        tok0.last = !(run_v && byte_v);
        tok1 = byte_tok;
        tok1.last = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            cand_reg  <= '0;
            len_reg   <= 8'd0;
            start_reg <= '0;
            pos_reg   <= '0;
        end else begin
            mode_reg  <= mode_next;
            cand_reg  <= cand_next;
            len_reg   <= len_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

[design/klex_outq.sv]
// three-entry result queue, takes up to two tokens per cycle, presents one
// depends on klex_pkg
`timescale 1ns / 1ps

module klex_outq
    import klex_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_n,
    input  token_t     tok0,
    input  token_t     tok1,
    output logic       room,
    output logic       m_tvalid,
    input  logic       m_tready,
    output token_t     m_tok
);

    token_t     slot_reg [QDEPTH];
    token_t     slot_next [QDEPTH];
    token_t     shifted [QDEPTH];
    logic [1:0] cnt_reg, cnt_next, cnt_ap;
    logic       pop;

    assign pop      = (cnt_reg != 2'd0) && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tok    = slot_reg[0];
    // room for two more regardless of what leaves this cycle
    assign room     = (cnt_reg <= 2'd1);

    always_comb begin
        for (int i = 0; i < QDEPTH - 1; i++) begin
            shifted[i] = pop ? slot_reg[i + 1] : slot_reg[i];
        end
        shifted[QDEPTH - 1] = slot_reg[QDEPTH - 1];
        cnt_ap = cnt_reg - 2'(pop);
        for (int i = 0; i < QDEPTH; i++) begin
            slot_next[i] = shifted[i];
            if ((push_n != 2'd0) && (cnt_ap == 2'(i))) begin
                slot_next[i] = tok0;
            end else if ((push_n == 2'd2) && ((cnt_ap + 2'd1) == 2'(i))) begin
                slot_next[i] = tok1;
            end
        end
        cnt_next = cnt_ap + push_n;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

[design/keyword_token_lexer.sv]
// data path: an accepted byte is held in in_byte_reg, decoded, and its tokens registered in
// the output queue; the first token is offered on the master side, the second once it is taken
// throughput: one byte per cycle while each byte gives at most one token and the master
// side does not stall; a byte that gives two tokens holds the slave side until one is taken
// reset: synchronous active-low aresetn clears scanner state, position and queue
// top level of the keyword token lexer; depends on klex_pkg, klex_scan, klex_outq
`timescale 1ns / 1ps

module keyword_token_lexer
    import klex_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = 255,
    parameter int INPUT_SPAN    = 65536
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [4:0] token_kind, [20:5] start_pos, [28:21] token_length
    output logic        m_tlast
);

    localparam logic [7:0] LEN_CAP = 8'((MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       room, proc;
    logic [1:0] push_n;
    token_t     tok0, tok1, m_tok;

    assign proc     = in_valid_reg && room;
    assign s_tready = !in_valid_reg || room;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    klex_scan #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .INPUT_SPAN   (INPUT_SPAN)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .proc     (proc),
        .char_code(in_byte_reg),
        .tok0     (tok0),
        .tok1     (tok1),
        .push_n   (push_n)
    );

    klex_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_n  (push_n),
        .tok0    (tok0),
        .tok1    (tok1),
        .room    (room),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tok   (m_tok)
    );

    assign m_tdata = {3'b000, m_tok.length, m_tok.start, m_tok.kind};
    assign m_tlast = m_tok.last;

    `include "keyword_token_lexer_assert.svh"

    `KLEX_ASSERT_RST(a_reset_empty, !m_tvalid && !in_valid_reg)
    `KLEX_ASSERT_NXT(a_held_byte, in_valid_reg && !room, in_valid_reg && $stable(in_byte_reg))
    `KLEX_ASSERT_IMP(a_eof_len, m_tvalid && (m_tok.kind == KIND_EOF), m_tok.length == 8'd0)
    `KLEX_ASSERT_IMP(a_len_cap, m_tvalid, m_tok.length <= LEN_CAP)
    `KLEX_ASSERT_IMP(a_no_push_idle, !proc, push_n == 2'd0)

endmodule
